// ===== hw/rtl/ptpd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptpd_pkg
// Shared types and constants of the periodic task priority dispatcher.
// ----------------------------------------------------------------------------
package ptpd_pkg;

  localparam int MAX_TASKS_DEF = 8;
  localparam int JOB_SLOTS_DEF = 8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;

  typedef struct packed {
    logic        command;
    logic [2:0]  task_index;
    logic [15:0] task_period;
    logic [15:0] task_offset;
    logic [15:0] task_deadline;
    logic [15:0] task_exec_time;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] running_task;
    logic       queue_overflow;
  } result_t;

  typedef struct packed {
    logic [15:0] period;
    logic [15:0] offset;
    logic [15:0] deadline;
    logic [15:0] exec_time;
  } task_t;

  typedef struct packed {
    logic [32:0] prio;
    logic [32:0] abs_deadline;
    logic [15:0] remaining;
    logic [2:0]  task_id;
    logic [15:0] seq;
  } job_t;

endpackage

// ===== hw/rtl/periodic_task_priority_dispatcher_top.sv =====
// ----------------------------------------------------------------------------
// periodic_task_priority_dispatcher_top
// Tick scheduler: task table and job store in registered-read memories.
// ----------------------------------------------------------------------------
// Channel  | Handshake          | Payload
// cmd      | start & !busy      | cmd (ptpd_pkg::cmd_t)
// result   | done strobe        | result (ptpd_pkg::result_t)
// cfg      | cfg_valid&cfg_ready| cfg_data (priority_mode)
//
// On a tick each task is read from memory and checked in the read, check
// and next-task states, and a task that passes the check goes on through a
// 32-step restoring remainder unit and the insert; the head search reads the
// job memory one slot at a time, in a read and a compare state per slot.
// Reset clears valid bits at once. The receiver cannot stall.
// ----------------------------------------------------------------------------
module periodic_task_priority_dispatcher_top #(
  parameter int MAX_TASKS = ptpd_pkg::MAX_TASKS_DEF,
  parameter int JOB_SLOTS = ptpd_pkg::JOB_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ptpd_pkg::cmd_t    cmd,
  output logic              done,
  output ptpd_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int SW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam int TC = $clog2(MAX_TASKS + 1);
  localparam int SC = $clog2(JOB_SLOTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_TRD   = 4'd2;
  localparam logic [3:0] S_TCHK  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_INS   = 4'd5;
  localparam logic [3:0] S_TNEXT = 4'd6;
  localparam logic [3:0] S_HRD   = 4'd7;
  localparam logic [3:0] S_HCMP  = 4'd8;
  localparam logic [3:0] S_HRD2  = 4'd9;
  localparam logic [3:0] S_UPD   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state;
  logic       mode;
  logic [31:0] now;
  logic [15:0] ins_seq;
  ptpd_pkg::cmd_t cmd_q;

  logic [MAX_TASKS-1:0] task_valid;
  logic [JOB_SLOTS-1:0] job_valid;
  ptpd_pkg::task_t task_mem [MAX_TASKS];
  ptpd_pkg::job_t  job_mem  [JOB_SLOTS];
  ptpd_pkg::task_t task_rd;
  ptpd_pkg::job_t  job_rd;

  logic          task_we;
  logic [TW-1:0] task_wa;
  logic [TW-1:0] task_ra;
  logic          job_we;
  logic [SW-1:0] job_wa;
  logic [SW-1:0] job_ra;
  ptpd_pkg::job_t job_wd;

  logic [TC-1:0] ti;
  logic [SC-1:0] si;
  logic [31:0]   diff;
  logic [15:0]   rem;
  logic [4:0]    dcnt;
  logic          overflow;
  logic          have_best;
  logic [SW-1:0] best;
  logic [32:0]   best_prio;
  logic [15:0]   best_age;

  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic [15:0] cand_age;
  logic [32:0] abs_dl;
  logic        free_found;
  logic [SW-1:0] free_slot;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (task_we) task_mem[task_wa] <= {cmd_q.task_period, cmd_q.task_offset,
                                       cmd_q.task_deadline, cmd_q.task_exec_time};
    task_rd <= task_mem[task_ra];
  end

  always_ff @(posedge clk) begin
    if (job_we) job_mem[job_wa] <= job_wd;
    job_rd <= job_mem[job_ra];
  end

  // Restoring remainder step: shift in one bit of the difference.
  assign rem_sh  = {rem, diff[31]};
  assign rem_sub = rem_sh - {1'b0, task_rd.period};
  assign abs_dl  = {1'b0, now} + {17'd0, task_rd.deadline};
  assign cand_age = ins_seq - job_rd.seq;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int s = JOB_SLOTS - 1; s >= 0; s--) begin
      if (!job_valid[s]) begin
        free_found = 1'b1;
        free_slot  = SW'(s);
      end
    end
  end

  always_comb begin
    task_we = (state == S_LOAD) && (32'(cmd_q.task_index) < 32'(MAX_TASKS));
    task_wa = TW'(cmd_q.task_index);
    task_ra = TW'(ti);
    job_ra  = (state == S_HRD2 || state == S_UPD) ? best : SW'(si);
    job_we  = 1'b0;
    job_wa  = free_slot;
    job_wd.prio         = mode ? abs_dl : {17'd0, task_rd.period};
    job_wd.abs_deadline = abs_dl;
    job_wd.remaining    = (task_rd.exec_time == 16'd0) ? 16'd1 : task_rd.exec_time;
    job_wd.task_id      = 3'(ti);
    job_wd.seq          = ins_seq;
    if (state == S_INS && free_found) job_we = 1'b1;
    if (state == S_UPD && job_rd.abs_deadline > {1'b0, now}) begin
      job_we = 1'b1;
      job_wa = best;
      job_wd = job_rd;
      job_wd.remaining = job_rd.remaining - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state      <= S_IDLE;
      mode       <= 1'b0;
      now        <= '0;
      ins_seq    <= '0;
      task_valid <= '0;
      job_valid  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) mode <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            ti    <= '0;
            overflow <= 1'b0;
            state <= (cmd.command == ptpd_pkg::CMD_LOAD) ? S_LOAD : S_TRD;
          end
        end
        S_LOAD: begin
          if (task_we) task_valid[task_wa] <= 1'b1;
          result <= '{status: ptpd_pkg::ST_LOAD, running_task: 3'd0,
                      queue_overflow: 1'b0};
          done  <= 1'b1;
          state <= S_DONE;
        end
        S_TRD: state <= S_TCHK;
        S_TCHK: begin
          if (task_valid[TW'(ti)] && task_rd.period != 16'd0 &&
              now >= {16'd0, task_rd.offset}) begin
            diff  <= now - {16'd0, task_rd.offset};
            rem   <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end else begin
            state <= S_TNEXT;
          end
        end
        S_DIV: begin
          diff <= {diff[30:0], 1'b0};
          rem  <= rem_sub[16] ? rem_sh[15:0] : rem_sub[15:0];
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd31) state <= S_INS;
        end
        S_INS: begin
          if (rem == 16'd0) begin
            if (free_found) begin
              job_valid[free_slot] <= 1'b1;
              ins_seq <= ins_seq + 16'd1;
            end else begin
              overflow <= 1'b1;
            end
          end
          state <= S_TNEXT;
        end
        S_TNEXT: begin
          if (32'(ti) == MAX_TASKS - 1) begin
            si <= '0;
            have_best <= 1'b0;
            state <= S_HRD;
          end else begin
            ti    <= ti + TC'(1);
            state <= S_TRD;
          end
        end
        S_HRD: state <= S_HCMP;
        S_HCMP: begin
          if (job_valid[SW'(si)] && (!have_best || job_rd.prio < best_prio ||
              (job_rd.prio == best_prio && cand_age > best_age))) begin
            have_best <= 1'b1;
            best      <= SW'(si);
            best_prio <= job_rd.prio;
            best_age  <= cand_age;
          end
          if (32'(si) == JOB_SLOTS - 1) begin
            state <= S_HRD2;
          end else begin
            si    <= si + SC'(1);
            state <= S_HRD;
          end
        end
        S_HRD2: begin
          if (have_best) begin
            state <= S_UPD;
          end else begin
            result <= '{status: ptpd_pkg::ST_IDLE, running_task: 3'd0,
                        queue_overflow: overflow};
            done  <= 1'b1;
            now   <= now + 32'd1;
            state <= S_DONE;
          end
        end
        S_UPD: begin
          if (job_rd.abs_deadline <= {1'b0, now}) begin
            result <= '{status: ptpd_pkg::ST_MISS, running_task: 3'd0,
                        queue_overflow: overflow};
          end else begin
            result <= '{status: ptpd_pkg::ST_RUN, running_task: job_rd.task_id,
                        queue_overflow: overflow};
            if (job_rd.remaining == 16'd1) job_valid[best] <= 1'b0;
          end
          done  <= 1'b1;
          now   <= now + 32'd1;
          state <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks the periodic task dispatcher against a cycle-free predictor: loads,
// releases, rate-monotonic and deadline-first ordering, misses and overflow.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  ptpd_pkg::cmd_t cmd = '0;
  logic done;
  ptpd_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  periodic_task_priority_dispatcher_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic            tsk_vld [8];
  ptpd_pkg::task_t tsk     [8];
  logic            job_vld [8];
  ptpd_pkg::job_t  job     [8];
  logic [31:0] now_ticks;
  logic [15:0] ins_seq;
  logic        mode;

  ptpd_pkg::result_t expected_results[$];
  int errors = 0;
  int n_results = 0;
  int n_miss = 0;
  int n_ovf = 0;

  task automatic clear_sched();
    for (int i = 0; i < 8; i++) begin
      tsk_vld[i] = 1'b0;
      tsk[i] = '0;
      job_vld[i] = 1'b0;
      job[i] = '0;
    end
    now_ticks = '0;
    ins_seq = '0;
    mode = 1'b0;
  endtask

  function automatic ptpd_pkg::result_t dispatch(ptpd_pkg::cmd_t c);
    ptpd_pkg::result_t r;
    logic [32:0] dl;
    int h;
    logic [15:0] best_age, age;
    logic placed;
    r = '0;
    r.status = ptpd_pkg::ST_IDLE;
    if (c.command == ptpd_pkg::CMD_LOAD) begin
      tsk_vld[c.task_index] = 1'b1;
      tsk[c.task_index].period = c.task_period;
      tsk[c.task_index].offset = c.task_offset;
      tsk[c.task_index].deadline = c.task_deadline;
      tsk[c.task_index].exec_time = c.task_exec_time;
      r.status = ptpd_pkg::ST_LOAD;
      return r;
    end
    for (int i = 0; i < 8; i++) begin
      if (tsk_vld[i] && tsk[i].period != 0 && now_ticks >= {16'd0, tsk[i].offset} &&
          ((now_ticks - tsk[i].offset) % tsk[i].period) == 0) begin
        dl = {1'b0, now_ticks} + tsk[i].deadline;
        placed = 1'b0;
        for (int s = 0; s < 8 && !placed; s++) begin
          if (!job_vld[s]) begin
            placed = 1'b1;
            job_vld[s] = 1'b1;
            job[s].prio = mode ? dl : {17'd0, tsk[i].period};
            job[s].abs_deadline = dl;
            job[s].remaining = tsk[i].exec_time == 0 ? 16'd1 : tsk[i].exec_time;
            job[s].task_id = i[2:0];
            job[s].seq = ins_seq;
            ins_seq++;
          end
        end
        if (!placed) r.queue_overflow = 1'b1;
      end
    end
    h = -1;
    best_age = '0;
    for (int s = 0; s < 8; s++) begin
      if (job_vld[s]) begin
        age = ins_seq - job[s].seq;
        if (h < 0 || job[s].prio < job[h].prio ||
            (job[s].prio == job[h].prio && age > best_age)) begin
          h = s;
          best_age = age;
        end
      end
    end
    if (h >= 0) begin
      if (job[h].abs_deadline <= {1'b0, now_ticks}) begin
        r.status = ptpd_pkg::ST_MISS;
      end else begin
        r.status = ptpd_pkg::ST_RUN;
        r.running_task = job[h].task_id;
        job[h].remaining--;
        if (job[h].remaining == 0) job_vld[h] = 1'b0;
      end
    end
    now_ticks++;
    return r;
  endfunction

  // bursts with random gaps
  int burst_left = 0;

  task automatic send_cmd(ptpd_pkg::cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(dispatch(c));
    start <= 1'b0;
    // start is already low at this edge, so the idle block captures no extra transaction
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode = m;
  endtask

  function automatic ptpd_pkg::cmd_t load_cmd(int idx, int per, int off, int dl, int ex);
    ptpd_pkg::cmd_t c;
    c.command = ptpd_pkg::CMD_LOAD;
    c.task_index = idx[2:0];
    c.task_period = per[15:0];
    c.task_offset = off[15:0];
    c.task_deadline = dl[15:0];
    c.task_exec_time = ex[15:0];
    return c;
  endfunction

  function automatic ptpd_pkg::cmd_t tick_cmd();
    ptpd_pkg::cmd_t c;
    c = '0;
    c.command = ptpd_pkg::CMD_TICK;
    c[63:0] = {$urandom, $urandom};
    c.task_index = 3'($urandom_range(0, 7));
    return c;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %p", result);
        errors++;
      end else begin
        ptpd_pkg::result_t e;
        e = expected_results.pop_front();
        n_results++;
        if (e.status == ptpd_pkg::ST_MISS) n_miss++;
        if (e.queue_overflow) n_ovf++;
        if (result.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, result.status);
          errors++;
        end
        if (result.running_task !== e.running_task) begin
          $error("running_task: expected %0d actual %0d", e.running_task,
                 result.running_task);
          errors++;
        end
        if (result.queue_overflow !== e.queue_overflow) begin
          $error("queue_overflow: expected %0d actual %0d", e.queue_overflow,
                 result.queue_overflow);
          errors++;
        end
      end
    end
  end

  task automatic test_directed_rm();
    write_mode(1'b0);
    send_cmd(tick_cmd());                           // idle on empty table
    send_cmd(load_cmd(0, 4, 0, 4, 1));
    send_cmd(load_cmd(1, 2, 1, 2, 0));              // zero exec time acts as one
    send_cmd(load_cmd(2, 0, 0, 5, 1));              // zero period never releases
    send_cmd(load_cmd(3, 65535, 65535, 65535, 65535));
    send_cmd(load_cmd(7, 4, 0, 4, 1));              // tie with task 0
    for (int i = 0; i < 10; i++) send_cmd(tick_cmd());
    wait_drain();
  endtask

  task automatic test_directed_edf_miss();
    write_mode(1'b1);
    send_cmd(load_cmd(4, 1, 0, 0, 3));              // zero deadline misses at once
    for (int i = 0; i < 3; i++) send_cmd(tick_cmd());
    wait_drain();
  endtask

  task automatic test_overflow();
    write_mode(1'b0);
    for (int i = 0; i < 8; i++) send_cmd(load_cmd(i, 1, 0, 65535, 65535));
    for (int i = 0; i < 4; i++) send_cmd(tick_cmd());
    wait_drain();
  endtask

  // fresh table per episode needs a store free of stuck jobs; reset is not
  // available, so the missed-deadline job stays and later phases see misses
  task automatic test_random(int n, logic m);
    ptpd_pkg::cmd_t c;
    write_mode(m);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 5) == 0) begin
        c = '0;
        c.command = ptpd_pkg::CMD_LOAD;
        c.task_index = 3'($urandom_range(0, 7));
        c.task_period = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                        16'($urandom_range(0, 12));
        c.task_offset = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                        16'($urandom_range(0, 40));
        c.task_deadline = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                          16'($urandom_range(0, 30));
        c.task_exec_time = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                           16'($urandom_range(0, 4));
        send_cmd(c);
      end else begin
        send_cmd(tick_cmd());
      end
    end
    wait_drain();
  endtask

  initial begin
    clear_sched();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_rm();
    test_random(200, 1'b1);
    test_random(120, 1'b0);
    test_directed_edf_miss();
    test_overflow();
    test_random(80, 1'b1);
    $display("Covered %0d results, %0d deadline misses, %0d overflow ticks,",
             n_results, n_miss, n_ovf);
    $display("both priority modes, with random sender gaps.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
